/* rtl/core/rmth_pkg.sv */
package rmth_pkg;

    localparam int unsigned CAPACITY_DEF    = 1024;
    localparam int unsigned SAMPLE_BITS_DEF = 32;
    localparam int unsigned COUNT_BITS      = 11;

    typedef enum logic [1:0] {
        t_SIFT_NONE = 2'd0,
        t_SIFT_UP   = 2'd1,
        t_SIFT_DOWN = 2'd2
    } t_sift_op;

    typedef struct packed {
        logic     start;
        t_sift_op op;
        logic     heap_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dp_sts;

endpackage

/* rtl/core/rmth_ram.sv */
module rmth_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/rmth_datapath.sv */
module rmth_datapath #(
    parameter int unsigned CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int unsigned SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF,
    localparam int unsigned HDEPTH = (CAPACITY + 1) / 2,
    localparam int unsigned AW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1,
    localparam int unsigned SW     = $clog2(HDEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rmth_pkg::t_dp_cmd      i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_value,
    output rmth_pkg::t_dp_sts      o_sts,
    output logic [SAMPLE_BITS-1:0] o_old_top
);
    // Engine for one heap operation. heap_sel 0 = lower (max), 1 = upper (min).
    typedef enum logic [2:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_DN_R2, S_DN_DEC
    } t_state;

    t_state                  r_state;
    logic                    r_sel;
    logic [SW-1:0]           r_idx;
    logic [SW-1:0]           r_size;
    logic [SAMPLE_BITS-1:0]  r_val;
    logic [SAMPLE_BITS-1:0]  r_lchild;
    logic                    r_done;

    logic [AW-1:0]          w_raddr, w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata, w_rd_lo, w_rd_up, w_rd;
    logic                   w_we_lo, w_we_up, w_we;

    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HDEPTH)) u_lo (
        .i_clk(i_clk), .i_we(w_we_lo), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rd_lo)
    );
    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HDEPTH)) u_up (
        .i_clk(i_clk), .i_we(w_we_up), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rd_up)
    );

    logic [SW-1:0] r_lsize, r_usize;
    assign w_rd = r_sel ? w_rd_up : w_rd_lo;

    // a ranks above b
    function automatic logic above(input logic [SAMPLE_BITS-1:0] a,
                                   input logic [SAMPLE_BITS-1:0] b,
                                   input logic sel);
        if (sel) begin
            above = $signed(a) < $signed(b);
        end else begin
            above = $signed(a) > $signed(b);
        end
    endfunction

    logic [SW-1:0] w_par, w_l, w_r, w_c;
    logic          w_rvalid, w_pick_r;
    logic [SAMPLE_BITS-1:0] w_cval;
    assign w_par    = (r_idx - SW'(1)) >> 1;
    assign w_l      = {r_idx[SW-2:0], 1'b0} + SW'(1);
    assign w_r      = w_l + SW'(1);
    assign w_rvalid = w_r < r_size;
    assign w_pick_r = w_rvalid && above(w_rd, r_lchild, r_sel);
    assign w_c      = w_pick_r ? w_r : w_l;
    assign w_cval   = w_pick_r ? w_rd : r_lchild;

    t_state                 n_state;
    logic [SW-1:0]          n_idx;
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_val;
        w_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                w_raddr = '0;
                if (i_cmd.start) begin
                    if (i_cmd.op == rmth_pkg::t_SIFT_UP) begin
                        n_state = S_UP_RD;
                        n_idx   = i_cmd.heap_sel ? r_usize : r_lsize;
                    end else if (i_cmd.op == rmth_pkg::t_SIFT_DOWN) begin
                        n_state = S_DN_RD;
                        n_idx   = '0;
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = w_par[AW-1:0];
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (above(r_val, w_rd, r_sel)) begin
                    w_we    = 1'b1;
                    w_wdata = w_rd;
                    n_idx   = w_par;
                    n_state = S_UP_RD;
                end else begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DN_RD: begin
                if (w_l >= r_size) begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = w_l[AW-1:0];
                    n_state = S_DN_R2;
                end
            end
            S_DN_R2: begin
                w_raddr = w_r[AW-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (above(w_cval, r_val, r_sel)) begin
                    w_we    = 1'b1;
                    w_wdata = w_cval;
                    n_idx   = w_c;
                    n_state = S_DN_RD;
                end else begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign w_we_lo = w_we && !r_sel;
    assign w_we_up = w_we && r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_lsize <= '0;
            r_usize <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= (r_state != S_IDLE) && (n_state == S_IDLE);
            if (r_state == S_DN_R2) begin
                r_lchild <= w_rd;
            end
            if (r_state == S_IDLE && i_cmd.start) begin
                r_sel <= i_cmd.heap_sel;
                r_val <= i_value;
                // the idle read at address 0 gives the current top
                o_old_top <= i_cmd.heap_sel ? w_rd_up : w_rd_lo;
                r_size <= i_cmd.heap_sel ? r_usize : r_lsize;
                if (i_cmd.op == rmth_pkg::t_SIFT_UP) begin
                    if (i_cmd.heap_sel) r_usize <= r_usize + SW'(1);
                    else                r_lsize <= r_lsize + SW'(1);
                end
            end
        end
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP) |-> (r_idx != '0))
        else $error("sift-up compare at root");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lsize <= SW'(HDEPTH)) && (r_usize <= SW'(HDEPTH)))
        else $error("heap size overflow");
endmodule

/* rtl/core/rmth_ctrl.sv */
module rmth_ctrl #(
    parameter int unsigned CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int unsigned SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SAMPLE_BITS:0]   o_median_times_two,
    output logic [rmth_pkg::COUNT_BITS-1:0] o_stored_count,
    output logic                   o_rejected_full,
    output rmth_pkg::t_dp_cmd      o_cmd,
    output logic [SAMPLE_BITS-1:0] o_value,
    input  rmth_pkg::t_dp_sts      i_sts,
    input  logic [SAMPLE_BITS-1:0] i_old_top
);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Tops are mirrored in registers; heap roots only change via these ops.
    typedef enum logic [2:0] {
        S_IDLE, S_OP1, S_WAIT1, S_OP2, S_WAIT2, S_RDTOP, S_TOPS, S_OUT
    } t_state;

    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_x, r_m, r_ltop, r_utop;
    logic [CW-1:0]          r_lsz, r_usz;
    logic                   r_even, r_repl, r_rej;

    logic signed [SAMPLE_BITS:0] w_sum;
    always_comb begin
        if (r_usz > r_lsz) begin
            w_sum = {r_utop[SAMPLE_BITS-1], r_utop} + {r_utop[SAMPLE_BITS-1], r_utop};
        end else if (r_lsz > r_usz) begin
            w_sum = {r_ltop[SAMPLE_BITS-1], r_ltop} + {r_ltop[SAMPLE_BITS-1], r_ltop};
        end else if (r_lsz == '0) begin
            w_sum = '0;
        end else begin
            w_sum = {r_ltop[SAMPLE_BITS-1], r_ltop} + {r_utop[SAMPLE_BITS-1], r_utop};
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = rmth_pkg::t_SIFT_NONE;
        o_value     = r_x;
        if (r_state == S_OP1) begin
            o_cmd.start    = 1'b1;
            o_cmd.op       = rmth_pkg::t_SIFT_DOWN;
            o_cmd.heap_sel = !r_even;
        end else if (r_state == S_OP2) begin
            o_cmd.start    = 1'b1;
            o_cmd.op       = rmth_pkg::t_SIFT_UP;
            o_cmd.heap_sel = r_even;
            o_value        = r_m;
        end else if (r_state == S_RDTOP) begin
            // fetch the new root of the heap that was sifted down
            o_cmd.start    = 1'b1;
            o_cmd.heap_sel = !r_even;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_lsz   <= '0;
            r_usz   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x    <= i_sample;
                        r_m    <= i_sample;
                        r_even <= (r_lsz == r_usz);
                        r_rej  <= ((r_lsz + r_usz) >= CW'(CAPACITY));
                        if ((r_lsz + r_usz) >= CW'(CAPACITY)) begin
                            r_state <= S_TOPS;
                        end else if (r_lsz == r_usz) begin
                            r_repl  <= (r_lsz != '0) && ($signed(r_ltop) > $signed(i_sample));
                            r_state <= ((r_lsz != '0) && ($signed(r_ltop) > $signed(i_sample)))
                                       ? S_OP1 : S_OP2;
                        end else begin
                            r_repl  <= $signed(r_utop) < $signed(i_sample);
                            r_state <= ($signed(r_utop) < $signed(i_sample)) ? S_OP1 : S_OP2;
                        end
                    end
                end
                S_OP1: r_state <= S_WAIT1;
                S_WAIT1: begin
                    if (i_sts.done) begin
                        r_m     <= i_old_top;
                        r_state <= S_OP2;
                    end
                end
                S_OP2: r_state <= S_WAIT2;
                S_WAIT2: begin
                    if (i_sts.done) begin
                        r_state <= S_RDTOP;
                    end
                end
                S_RDTOP: r_state <= S_TOPS;
                S_TOPS: begin
                    if (!r_rej) begin
                        // new root is the pushed value if it outranks the old root
                        if (r_even) begin
                            r_usz <= r_usz + CW'(1);
                            if (r_usz == '0 || $signed(r_m) < $signed(r_utop)) r_utop <= r_m;
                            if (r_repl) r_ltop <= i_old_top;
                        end else begin
                            r_lsz <= r_lsz + CW'(1);
                            if (r_lsz == '0 || $signed(r_m) > $signed(r_ltop)) r_ltop <= r_m;
                            if (r_repl) r_utop <= i_old_top;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the previous word has been taken
                    if (!o_valid || !i_stall) begin
                        o_valid            <= 1'b1;
                        o_median_times_two <= w_sum;
                        o_stored_count     <= rmth_pkg::COUNT_BITS'(r_lsz + r_usz);
                        o_rejected_full    <= r_rej;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lsz + r_usz) <= CW'(CAPACITY))
        else $error("count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_usz == r_lsz) || (r_usz == r_lsz + CW'(1)))
        else $error("halves out of balance");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT2 && i_sts.done) |=> (r_state == S_RDTOP))
        else $error("sequencer lost done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OP1 || r_state == S_OP2 || r_state == S_RDTOP) |-> !i_sts.busy)
        else $error("command while engine busy");
endmodule

/* rtl/core/running_median_two_heap_core.sv */
// Running median over a signed sample stream, kept in a max-heap (lower half) and a
// min-heap (upper half), each in its own RAM of (CAPACITY+1)/2 words. Each word yields
// one result word: twice the median (exact), the stored count, and a full flag; a sample
// offered when CAPACITY samples are held is dropped and flagged. One item takes one
// optional replace-top sift-down plus one push sift-up on the shared RAM read
// address, then a re-read of the sifted root; a dropped word skips the heap
// operations, and a result word still held by i_stall holds up the next one. The
// block takes one word at a time.
module running_median_two_heap_core #(
    parameter int unsigned CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int unsigned SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SAMPLE_BITS:0]   o_median_times_two,
    output logic [rmth_pkg::COUNT_BITS-1:0] o_stored_count,
    output logic                   o_rejected_full
);
    rmth_pkg::t_dp_cmd      w_cmd;
    rmth_pkg::t_dp_sts      w_sts;
    logic [SAMPLE_BITS-1:0] w_value, w_old_top;

    rmth_ctrl #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_median_times_two(o_median_times_two),
        .o_stored_count(o_stored_count), .o_rejected_full(o_rejected_full),
        .o_cmd(w_cmd), .o_value(w_value), .i_sts(w_sts), .i_old_top(w_old_top)
    );

    rmth_datapath #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_value(w_value), .o_sts(w_sts), .o_old_top(w_old_top)
    );
endmodule
